[hdl/nrs_pkg.sv]
// Shared constants and types for the nested range suppressor.
// No dependencies; imported by every module of the block.
`default_nettype none

package nrs_pkg;

    // Default widths of positions and output indexes
    localparam int POS_WIDTH_DEF   = 32;
    localparam int INDEX_WIDTH_DEF = 24;

    // Fixed width of the opaque line tag
    localparam int TAG_WIDTH = 24;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

`default_nettype wire

[hdl/nrs_front.sv]
// Front part: holds the current range, classifies each line and builds
// a queue entry with up to two results. Depends on nrs_pkg.
`default_nettype none

module nrs_front #(
    parameter int POS_WIDTH   = nrs_pkg::POS_WIDTH_DEF,
    parameter int INDEX_WIDTH = nrs_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [POS_WIDTH-1:0]                   range_begin,
    input  logic [POS_WIDTH-1:0]                   range_end,
    input  logic                                   line_defined,
    input  logic [nrs_pkg::TAG_WIDTH-1:0]          line_tag,
    input  logic                                   end_of_list,
    input  nrs_pkg::q_status_t                     q_status,
    output logic                                   push,
    output logic [2*(2*POS_WIDTH+nrs_pkg::TAG_WIDTH+INDEX_WIDTH+2):0] push_entry
);
    import nrs_pkg::*;

    localparam int REC_W = 2 * POS_WIDTH + TAG_WIDTH + INDEX_WIDTH + 2;

    // Held range state
    logic                   held_valid_reg, held_valid_next;
    logic [POS_WIDTH-1:0]   held_begin_reg, held_begin_next;
    logic [POS_WIDTH-1:0]   held_end_reg, held_end_next;
    logic [TAG_WIDTH-1:0]   held_tag_reg, held_tag_next;
    logic [INDEX_WIDTH-1:0] count_reg, count_next;

    logic                   accept;
    logic                   nested;
    logic                   covers;
    logic                   displace;
    logic [REC_W-1:0]       rec_displaced;
    logic [REC_W-1:0]       rec_final;
    logic [REC_W-1:0]       rec0;
    logic [REC_W-1:0]       rec1;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && !q_status.full;

    // Classification against the held range
    assign nested   = held_valid_reg && (held_begin_reg <= range_begin)
                      && (held_end_reg >= range_end);
    assign covers   = held_valid_reg && (held_begin_reg >= range_begin)
                      && (held_end_reg <= range_end);
    assign displace = line_defined && held_valid_reg && !nested && !covers;

    assign count_next = displace ? count_reg + 1'b1 : count_reg;

    // Held range after this line, before any end-of-list clear
    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_begin_next = held_begin_reg;
        held_end_next   = held_end_reg;
        held_tag_next   = held_tag_reg;
        if (line_defined && !nested)
        begin
            held_valid_next = 1'b1;
            held_begin_next = range_begin;
            held_end_next   = range_end;
            held_tag_next   = line_tag;
        end
    end

    // Result records, fields from the lowest bit up:
    // begin, end, tag, position, has_range, last
    assign rec_displaced = {1'b0, 1'b1, count_reg, held_tag_reg,
                            held_end_reg, held_begin_reg};

    always_comb
    begin
        if (held_valid_next)
            rec_final = {1'b1, 1'b1, count_next, held_tag_next,
                         held_end_next, held_begin_next};
        else
            rec_final = {1'b1, 1'b0, {(REC_W-2){1'b0}}};
    end

    // Queue entry: two-result flag at bit 0, then first and second record
    always_comb
    begin
        rec0 = displace ? rec_displaced : rec_final;
        rec1 = rec_final;
    end

    assign push       = accept && (displace || end_of_list);
    assign push_entry = {rec1, rec0, displace && end_of_list};

    // State update; end of list returns to the reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_begin_reg <= '0;
            held_end_reg   <= '0;
            held_tag_reg   <= '0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            if (end_of_list)
            begin
                held_valid_reg <= 1'b0;
                held_begin_reg <= '0;
                held_end_reg   <= '0;
                held_tag_reg   <= '0;
                count_reg      <= '0;
            end
            else
            begin
                held_valid_reg <= held_valid_next;
                held_begin_reg <= held_begin_next;
                held_end_reg   <= held_end_next;
                held_tag_reg   <= held_tag_next;
                count_reg      <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/nrs_queue.sv]
// Short queue of result entries between the front and the back part.
// Depends on nrs_pkg for the depth and the status struct.
`default_nettype none

module nrs_queue #(
    parameter int ENTRY_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_entry,
    input  logic               pop,
    output logic [ENTRY_W-1:0] head_entry,
    output nrs_pkg::q_status_t q_status
);
    import nrs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_W-1:0] slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_pop;

    assign do_pop             = pop && (count_reg != '0);
    assign q_status.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.not_empty = (count_reg != '0);
    assign head_entry         = slots_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

[hdl/nrs_back.sv]
// Back part: takes queue entries, sends their one or two results through
// an output register. Depends on nrs_pkg.
`default_nettype none

module nrs_back #(
    parameter int REC_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nrs_pkg::q_status_t q_status,
    input  logic [2*REC_W:0]   head_entry,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [REC_W-1:0]   out_rec
);
    import nrs_pkg::*;

    logic             out_valid_reg, out_valid_next;
    logic [REC_W-1:0] out_rec_reg, out_rec_next;
    logic             phase_reg, phase_next;
    logic             load;
    logic             two_results;
    logic [REC_W-1:0] rec0;
    logic [REC_W-1:0] rec1;

    assign two_results = head_entry[0];
    assign rec0        = head_entry[REC_W:1];
    assign rec1        = head_entry[2*REC_W:REC_W+1];

    // Output register is free when empty or its transaction completes
    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        pop            = 1'b0;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rec_next   = out_rec_reg;
        if (load && q_status.not_empty)
        begin
            out_valid_next = 1'b1;
            out_rec_next   = phase_reg ? rec1 : rec0;
            if (two_results && !phase_reg)
                phase_next = 1'b1;
            else
            begin
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        out_rec_reg <= out_rec_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

endmodule

`default_nettype wire

[hdl/nested_range_suppressor_unit.sv]
// Top level of the nested range suppressor: stream ports, front, queue
// and back. Depends on nrs_pkg, nrs_front, nrs_queue and nrs_back.
//
// The block takes one line per cycle and drops ranges nested in the
// currently held range; a range that covers the held one replaces it.
// A held range goes out when a line displaces it, and the line marked
// tlast flushes it with tlast set (or an empty marker, tuser low, if no
// range was kept), after which a new list starts. Input lines are taken
// every cycle while the four-entry queue has room; results leave at one
// per cycle from the output register while m_tready is high, after
// passing through a queue slot. A last line that displaces the held
// range produces two results and holds the back part, which the queue absorbs.
`default_nettype none

module nested_range_suppressor_unit #(
    parameter int POS_WIDTH   = nrs_pkg::POS_WIDTH_DEF,
    parameter int INDEX_WIDTH = nrs_pkg::INDEX_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // Line input
    input  logic s_tvalid,
    output logic s_tready,
    // range_begin, range_end, line_tag (zero padded to bytes)
    input  logic [((2*POS_WIDTH+nrs_pkg::TAG_WIDTH+7)/8)*8-1:0] s_tdata,
    // line_defined
    input  logic s_tuser,
    // end_of_list
    input  logic s_tlast,
    // Result output
    output logic m_tvalid,
    input  logic m_tready,
    // out_begin, out_end, out_tag, out_position (zero padded to bytes)
    output logic [((2*POS_WIDTH+nrs_pkg::TAG_WIDTH+INDEX_WIDTH+7)/8)*8-1:0] m_tdata,
    // out_has_range
    output logic m_tuser,
    // out_last
    output logic m_tlast
);
    import nrs_pkg::*;

    localparam int M_DATA_W = ((2*POS_WIDTH + TAG_WIDTH + INDEX_WIDTH + 7) / 8) * 8;
    localparam int REC_W    = 2 * POS_WIDTH + TAG_WIDTH + INDEX_WIDTH + 2;
    localparam int ENTRY_W  = 2 * REC_W + 1;

    logic                 push;
    logic                 pop;
    logic [ENTRY_W-1:0]   push_entry;
    logic [ENTRY_W-1:0]   head_entry;
    q_status_t            q_status;
    logic [REC_W-1:0]     out_rec;

    // Front: classify lines against the held range
    nrs_front #(
        .POS_WIDTH   (POS_WIDTH),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .range_begin  (s_tdata[POS_WIDTH-1:0]),
        .range_end    (s_tdata[2*POS_WIDTH-1:POS_WIDTH]),
        .line_defined (s_tuser),
        .line_tag     (s_tdata[2*POS_WIDTH+TAG_WIDTH-1:2*POS_WIDTH]),
        .end_of_list  (s_tlast),
        .q_status     (q_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    // Queue between front and back
    nrs_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    // Back: serialize results into the output register
    nrs_back #(
        .REC_W (REC_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rec    (out_rec)
    );

    // Record layout matches tdata from the lowest bit; flags on top
    assign m_tdata = M_DATA_W'(out_rec[REC_W-3:0]);
    assign m_tuser = out_rec[REC_W-2];
    assign m_tlast = out_rec[REC_W-1];

endmodule

`default_nettype wire
